>>> hw/rtl/brf_pkg.sv
// Package with the shared constants, types and transaction formats of the byte ring FIFO.
package brf_pkg;

  localparam int DEPTH = 256;
  localparam int AW    = $clog2(DEPTH);
  localparam int CW    = 9;
  localparam int DW    = 8;
  localparam int LW    = CW + 3;

  localparam logic [CW-1:0] CAP_MAX = CW'(DEPTH);
  localparam logic [CW-1:0] CAP_MIN = CW'(1);

  typedef enum logic [1:0] {
    OP_WRITE = 2'd0,
    OP_READ  = 2'd1,
    OP_CLEAR = 2'd2,
    OP_NOP   = 2'd3
  } brf_op_t;

  typedef struct packed {
    brf_op_t         op;
    logic [DW-1:0]   write_byte;
    logic            burst_end;
  } brf_in_item_t;

  typedef struct packed {
    logic [DW-1:0]   read_byte;
    logic            read_valid;
    logic            write_taken;
    logic [CW-1:0]   fill_count;
    logic [CW-1:0]   free_space;
    logic            is_empty;
    logic            is_full;
    logic            almost_empty;
    logic            almost_full;
    logic            overflowed;
    logic            last;
  } brf_out_item_t;

  typedef struct packed {
    logic            wr_en;
    logic            rd_en;
    logic [AW-1:0]   addr;
    logic [DW-1:0]   wdata;
  } brf_ram_cmd_t;

  typedef struct packed {
    logic            read_valid;
    logic            write_taken;
    logic [CW-1:0]   fill_count;
    logic [CW-1:0]   free_space;
    logic            is_empty;
    logic            is_full;
    logic            almost_empty;
    logic            almost_full;
    logic            overflowed;
    logic            last;
  } brf_status_t;

endpackage

>>> hw/rtl/brf_ram.sv
// Generic single-port synchronous RAM with a registered read port.
module brf_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 256
) (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic                     rd_en,
  input  logic [$clog2(DEPTH)-1:0] addr,
  input  logic [WIDTH-1:0]         wdata,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[addr] <= wdata;
    end
    if (rd_en) begin
      rdata_r <= mem[addr];
    end
  end

  assign rdata = rdata_r;

endmodule

>>> hw/rtl/brf_ctrl.sv
// Pointer, level and flag control that turns each transaction into a RAM access and status.
module brf_ctrl (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  cfg_wr_en,
  input  logic [brf_pkg::CW-1:0] cfg_wr_data,
  input  logic                  accept,
  input  brf_pkg::brf_in_item_t item,
  output brf_pkg::brf_ram_cmd_t ram_cmd,
  output brf_pkg::brf_status_t  status
);
  import brf_pkg::*;

  logic [CW-1:0] cap_r, cap_nxt;
  logic [AW-1:0] head_r, head_nxt;
  logic [CW-1:0] count_r, count_nxt;
  logic          ovf_r, ovf_nxt;
  logic [CW-1:0] pos_sum;
  logic [CW-1:0] pos_wrap;
  logic [CW-1:0] head_inc;
  logic [LW-1:0] count_x5;
  logic [LW-1:0] cap_x4;
  logic          rvalid;
  logic          wtaken;

  always_comb begin
    pos_sum  = CW'(head_r) + count_r;
    pos_wrap = (pos_sum >= cap_r) ? (pos_sum - cap_r) : pos_sum;
    head_inc = CW'(head_r) + CW'(1);
  end

  always_comb begin
    cap_nxt   = cap_r;
    head_nxt  = head_r;
    count_nxt = count_r;
    ovf_nxt   = ovf_r;
    rvalid    = 1'b0;
    wtaken    = 1'b0;
    ram_cmd   = '{wr_en: 1'b0, rd_en: 1'b0, addr: head_r, wdata: item.write_byte};
    if (cfg_wr_en) begin
      if (cfg_wr_data == '0) begin
        cap_nxt = CAP_MIN;
      end else if (cfg_wr_data > CAP_MAX) begin
        cap_nxt = CAP_MAX;
      end else begin
        cap_nxt = cfg_wr_data;
      end
      head_nxt  = '0;
      count_nxt = '0;
      ovf_nxt   = 1'b0;
    end else if (accept) begin
      unique case (item.op)
        OP_WRITE: begin
          if (count_r < cap_r) begin
            ram_cmd.wr_en = 1'b1;
            ram_cmd.addr  = pos_wrap[AW-1:0];
            count_nxt     = count_r + CW'(1);
            wtaken        = 1'b1;
          end else begin
            ovf_nxt = 1'b1;
          end
        end
        OP_READ: begin
          if (count_r != '0) begin
            ram_cmd.rd_en = 1'b1;
            ram_cmd.addr  = head_r;
            rvalid        = 1'b1;
            head_nxt      = (head_inc >= cap_r) ? '0 : head_inc[AW-1:0];
            count_nxt     = count_r - CW'(1);
          end
        end
        OP_CLEAR: begin
          head_nxt  = '0;
          count_nxt = '0;
          ovf_nxt   = 1'b0;
        end
        OP_NOP: begin
        end
        default: begin
        end
      endcase
    end
  end

  always_comb begin
    count_x5 = (LW'(count_nxt) << 2) + LW'(count_nxt);
    cap_x4   = LW'(cap_r) << 2;
    status.read_valid   = rvalid;
    status.write_taken  = wtaken;
    status.fill_count   = count_nxt;
    status.free_space   = cap_r - count_nxt;
    status.is_empty     = (count_nxt == '0);
    status.is_full      = (count_nxt == cap_r);
    status.almost_empty = (count_x5 <= LW'(cap_r));
    status.almost_full  = (count_x5 >= cap_x4);
    status.overflowed   = ovf_nxt;
    status.last         = item.burst_end;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cap_r   <= CAP_MAX;
      head_r  <= '0;
      count_r <= '0;
      ovf_r   <= 1'b0;
    end else begin
      cap_r   <= cap_nxt;
      head_r  <= head_nxt;
      count_r <= count_nxt;
      ovf_r   <= ovf_nxt;
    end
  end

endmodule

>>> hw/rtl/byte_ring_fifo_with_level_flags_core.sv
// Top level of the byte ring FIFO with level flags.
//
// Each input transaction carries one operation: write a byte, read a byte, clear, or no-op.
// Every accepted transaction yields exactly one result transaction that reports the byte
// read, whether a write was stored, the level, the free space and the status flags.
// The cfg port sets the capacity in use (1 to 256) and also clears the FIFO; the user must
// write it only while no transaction is in flight, and the block itself does not enforce this.
// The byte store is one 256 x 8 single-port RAM with a registered read port.
// Pointer and level state update at the edge that accepts a transaction, and the RAM
// access for it is issued at that same edge.
// The RAM registers its read data at the edge that accepts the input transaction, and the
// output register takes the result from that read stage; out_valid rises with it.
// Throughput: one transaction per cycle while out_stall stays low.
// When out_stall is high the output register holds its result, the read stage behind it
// fills, and in_stall rises once both are occupied; nothing is lost or repeated.
// Reset clears the FIFO and its overflow flag and sets the capacity to 256; the RAM
// contents are not cleared and no entry is read before it has been written.
module byte_ring_fifo_with_level_flags_core (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   cfg_wr_en,
  input  logic [brf_pkg::CW-1:0] cfg_wr_data,
  input  logic                   in_valid,
  output logic                   in_stall,
  input  brf_pkg::brf_in_item_t  in_item,
  output logic                   out_valid,
  input  logic                   out_stall,
  output brf_pkg::brf_out_item_t out_item
);
  import brf_pkg::*;

  brf_ram_cmd_t  ram_cmd;
  brf_status_t   status;
  logic [DW-1:0] ram_rdata;
  logic          accept;
  logic          s1_adv;
  logic          s1_valid_r, s1_valid_nxt;
  brf_status_t   s1_status_r;
  logic          out_valid_r, out_valid_nxt;
  brf_out_item_t out_item_r;
  brf_out_item_t s1_item;

  assign s1_adv   = s1_valid_r && (!out_valid_r || !out_stall);
  assign in_stall = s1_valid_r && !s1_adv;
  assign accept   = in_valid && !in_stall;

  brf_ctrl u_ctrl (
    .clk         (clk),
    .rst_n       (rst_n),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_wr_data (cfg_wr_data),
    .accept      (accept),
    .item        (in_item),
    .ram_cmd     (ram_cmd),
    .status      (status)
  );

  brf_ram #(
    .WIDTH (DW),
    .DEPTH (DEPTH)
  ) u_ram (
    .clk   (clk),
    .wr_en (ram_cmd.wr_en),
    .rd_en (ram_cmd.rd_en),
    .addr  (ram_cmd.addr),
    .wdata (ram_cmd.wdata),
    .rdata (ram_rdata)
  );

  always_comb begin
    s1_item.read_byte    = s1_status_r.read_valid ? ram_rdata : '0;
    s1_item.read_valid   = s1_status_r.read_valid;
    s1_item.write_taken  = s1_status_r.write_taken;
    s1_item.fill_count   = s1_status_r.fill_count;
    s1_item.free_space   = s1_status_r.free_space;
    s1_item.is_empty     = s1_status_r.is_empty;
    s1_item.is_full      = s1_status_r.is_full;
    s1_item.almost_empty = s1_status_r.almost_empty;
    s1_item.almost_full  = s1_status_r.almost_full;
    s1_item.overflowed   = s1_status_r.overflowed;
    s1_item.last         = s1_status_r.last;
  end

  always_comb begin
    s1_valid_nxt  = accept || (s1_valid_r && !s1_adv);
    out_valid_nxt = s1_adv || (out_valid_r && out_stall);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      s1_valid_r  <= s1_valid_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      s1_status_r <= status;
    end
    if (s1_adv) begin
      out_item_r <= s1_item;
    end
  end

  assign out_valid = out_valid_r;
  assign out_item  = out_item_r;

endmodule

>>> tb/tb_top.sv
// Self-checking testbench for the byte ring FIFO core with level flags.
`timescale 1ns / 100ps

module tb_top;
  import brf_pkg::*;

  localparam int CYCLE_LIMIT = 200_000;
  localparam int NUM_PHASES  = 9;

  typedef struct {
    bit            is_cfg;
    logic [CW-1:0] cfg_val;
    brf_in_item_t  item;
    bit            typed;
    brf_out_item_t want;
  } stim_row_t;

  typedef struct {
    logic [CW-1:0] cap;
    int            n_items;
    int            wr_pct;
    bit            flip;
    int            clr_pct;
    bit            rand_cap;
  } phase_t;

  logic          clk;
  logic          rst_n;
  logic          cfg_wr_en;
  logic [CW-1:0] cfg_wr_data;
  logic          in_valid;
  logic          in_stall;
  brf_in_item_t  in_item;
  logic          out_valid;
  logic          out_stall = 1'b0;
  brf_out_item_t out_item;

  logic [DW-1:0] ring_mem [DEPTH];
  int            ring_head;
  int            ring_count;
  bit            ring_ovf;
  logic [CW-1:0] cap_reg;

  brf_out_item_t pending_status [$];
  stim_row_t     script [$];
  phase_t        plan [NUM_PHASES];
  int            send_idle_pct = 0;
  int            recv_stall_pct = 0;
  int            mismatches = 0;
  int            cycle_cnt = 0;

  byte_ring_fifo_with_level_flags_core u_dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg_wr_en  (cfg_wr_en),
    .cfg_wr_data(cfg_wr_data),
    .in_valid   (in_valid),
    .in_stall   (in_stall),
    .in_item    (in_item),
    .out_valid  (out_valid),
    .out_stall  (out_stall),
    .out_item   (out_item)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  function automatic brf_out_item_t fifo_apply(brf_in_item_t it);
    brf_out_item_t r;
    int cap;
    int pos;
    r = '0;
    if (cap_reg == 0) cap = 1;
    else if (cap_reg > DEPTH) cap = DEPTH;
    else cap = int'(cap_reg);
    if (ring_head >= cap) ring_head = 0;
    if (ring_count > cap) ring_count = cap;
    case (it.op)
      OP_WRITE: begin
        if (ring_count < cap) begin
          pos = ring_head + ring_count;
          if (pos >= cap) pos -= cap;
          ring_mem[pos] = it.write_byte;
          ring_count++;
          r.write_taken = 1'b1;
        end else begin
          ring_ovf = 1'b1;
        end
      end
      OP_READ: begin
        if (ring_count > 0) begin
          r.read_byte = ring_mem[ring_head];
          r.read_valid = 1'b1;
          ring_head++;
          if (ring_head >= cap) ring_head = 0;
          ring_count--;
        end
      end
      OP_CLEAR: begin
        ring_head = 0;
        ring_count = 0;
        ring_ovf = 1'b0;
      end
      default: ;
    endcase
    r.fill_count = CW'(ring_count);
    r.free_space = CW'(cap - ring_count);
    r.is_empty = (ring_count == 0);
    r.is_full = (ring_count == cap);
    r.almost_empty = (ring_count * 10 <= cap * 2);
    r.almost_full = (ring_count * 10 >= cap * 8);
    r.overflowed = ring_ovf;
    r.last = it.burst_end;
    return r;
  endfunction

  function automatic brf_in_item_t random_op(int wr_pct, int clr_pct, bit run_end);
    brf_in_item_t it;
    int roll;
    roll = $urandom_range(99);
    it.write_byte = DW'($urandom);
    it.burst_end = run_end;
    if (roll < clr_pct) it.op = OP_CLEAR;
    else if (roll < clr_pct + 3) it.op = OP_NOP;
    else if ($urandom_range(99) < wr_pct) it.op = OP_WRITE;
    else it.op = OP_READ;
    return it;
  endfunction

  function automatic stim_row_t op_row(brf_op_t op, logic [DW-1:0] b, logic be);
    stim_row_t row;
    row = '{default: '0};
    row.item.op = op;
    row.item.write_byte = b;
    row.item.burst_end = be;
    return row;
  endfunction

  function automatic stim_row_t chk_row(brf_op_t op, logic [DW-1:0] b, logic be,
                                       brf_out_item_t want);
    stim_row_t row;
    row = op_row(op, b, be);
    row.typed = 1'b1;
    row.want = want;
    return row;
  endfunction

  function automatic stim_row_t cfg_row(logic [CW-1:0] v);
    stim_row_t row;
    row = '{default: '0};
    row.is_cfg = 1'b1;
    row.cfg_val = v;
    return row;
  endfunction

  task automatic drain_results();
    in_valid <= 1'b0;
    while (pending_status.size() != 0) @(negedge clk);
  endtask

  task automatic set_capacity(input logic [CW-1:0] value);
    drain_results();
    cfg_wr_en <= 1'b1;
    cfg_wr_data <= value;
    @(negedge clk);
    cfg_wr_en <= 1'b0;
    cap_reg = value;
    ring_head = 0;
    ring_count = 0;
    ring_ovf = 1'b0;
  endtask

  task automatic send_op(input brf_in_item_t it, input bit typed, input brf_out_item_t want);
    brf_out_item_t predicted;
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    predicted = fifo_apply(it);
    pending_status.push_back(typed ? want : predicted);
    in_valid <= 1'b1;
    in_item <= it;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    @(negedge clk);
  endtask

  task automatic check_field(input string name, input logic [CW-1:0] want,
                             input logic [CW-1:0] got);
    if (got !== want) begin
      $display("%0t: %s expected %0d actual %0d", $time, name, want, got);
      mismatches++;
    end
  endtask

  always @(negedge clk) begin
    out_stall <= ($urandom_range(99) < recv_stall_pct);
  end

  always @(posedge clk) begin
    brf_out_item_t want;
    if (rst_n && out_valid !== 1'b0 && out_stall == 1'b0) begin
      if (pending_status.size() == 0) begin
        $display("%0t: unexpected result, expected none, actual %p", $time, out_item);
        mismatches++;
      end else begin
        want = pending_status.pop_front();
        check_field("read_byte", CW'(want.read_byte), CW'(out_item.read_byte));
        check_field("read_valid", CW'(want.read_valid), CW'(out_item.read_valid));
        check_field("write_taken", CW'(want.write_taken), CW'(out_item.write_taken));
        check_field("fill_count", want.fill_count, out_item.fill_count);
        check_field("free_space", want.free_space, out_item.free_space);
        check_field("is_empty", CW'(want.is_empty), CW'(out_item.is_empty));
        check_field("is_full", CW'(want.is_full), CW'(out_item.is_full));
        check_field("almost_empty", CW'(want.almost_empty), CW'(out_item.almost_empty));
        check_field("almost_full", CW'(want.almost_full), CW'(out_item.almost_full));
        check_field("overflowed", CW'(want.overflowed), CW'(out_item.overflowed));
        check_field("last", CW'(want.last), CW'(out_item.last));
      end
    end
  end

  always @(posedge clk) begin
    cycle_cnt <= cycle_cnt + 1;
    if (cycle_cnt >= CYCLE_LIMIT) begin
      $display("CHECKS FAILED");
      $finish;
    end
  end

  initial begin
    int p;
    int n;
    int run_left;
    int bias;
    logic [CW-1:0] cap_val;
    rst_n = 1'b0;
    in_valid = 1'b0;
    in_item = '0;
    cfg_wr_en = 1'b0;
    cfg_wr_data = '0;
    cap_reg = CAP_MAX;
    ring_head = 0;
    ring_count = 0;
    ring_ovf = 1'b0;

    script.push_back(chk_row(OP_READ, 8'h00, 1'b1, brf_out_item_t'{8'h00, 1'b0, 1'b0,
      9'd0, 9'd256, 1'b1, 1'b0, 1'b1, 1'b0, 1'b0, 1'b1}));
    script.push_back(chk_row(OP_WRITE, 8'hFF, 1'b0, brf_out_item_t'{8'h00, 1'b0, 1'b1,
      9'd1, 9'd255, 1'b0, 1'b0, 1'b1, 1'b0, 1'b0, 1'b0}));
    script.push_back(op_row(OP_WRITE, 8'h00, 1'b0));
    script.push_back(op_row(OP_WRITE, 8'hA5, 1'b1));
    script.push_back(chk_row(OP_READ, 8'h00, 1'b0, brf_out_item_t'{8'hFF, 1'b1, 1'b0,
      9'd2, 9'd254, 1'b0, 1'b0, 1'b1, 1'b0, 1'b0, 1'b0}));
    script.push_back(op_row(OP_NOP, 8'h5A, 1'b1));
    script.push_back(op_row(OP_READ, 8'h00, 1'b0));
    script.push_back(chk_row(OP_CLEAR, 8'h00, 1'b1, brf_out_item_t'{8'h00, 1'b0, 1'b0,
      9'd0, 9'd256, 1'b1, 1'b0, 1'b1, 1'b0, 1'b0, 1'b1}));
    script.push_back(cfg_row(9'd0));
    script.push_back(chk_row(OP_WRITE, 8'h00, 1'b1, brf_out_item_t'{8'h00, 1'b0, 1'b1,
      9'd1, 9'd0, 1'b0, 1'b1, 1'b0, 1'b1, 1'b0, 1'b1}));
    script.push_back(chk_row(OP_WRITE, 8'h55, 1'b0, brf_out_item_t'{8'h00, 1'b0, 1'b0,
      9'd1, 9'd0, 1'b0, 1'b1, 1'b0, 1'b1, 1'b1, 1'b0}));
    script.push_back(op_row(OP_NOP, 8'hFF, 1'b0));
    script.push_back(chk_row(OP_READ, 8'h00, 1'b0, brf_out_item_t'{8'h00, 1'b1, 1'b0,
      9'd0, 9'd1, 1'b1, 1'b0, 1'b1, 1'b0, 1'b1, 1'b0}));
    script.push_back(op_row(OP_READ, 8'h00, 1'b1));
    script.push_back(op_row(OP_CLEAR, 8'h00, 1'b0));
    script.push_back(cfg_row(9'd511));
    script.push_back(op_row(OP_WRITE, 8'h80, 1'b0));
    script.push_back(op_row(OP_WRITE, 8'h7F, 1'b1));
    script.push_back(cfg_row(9'd2));
    script.push_back(op_row(OP_WRITE, 8'h01, 1'b0));
    script.push_back(op_row(OP_WRITE, 8'h02, 1'b0));
    script.push_back(op_row(OP_WRITE, 8'h03, 1'b0));
    script.push_back(op_row(OP_READ, 8'h00, 1'b0));
    script.push_back(op_row(OP_WRITE, 8'h04, 1'b0));
    script.push_back(op_row(OP_READ, 8'h00, 1'b0));
    script.push_back(op_row(OP_READ, 8'h00, 1'b1));

    plan[0] = '{9'd1,   45,  60, 1'b1, 2, 1'b0};
    plan[1] = '{9'd4,   45,  70, 1'b1, 2, 1'b0};
    plan[2] = '{9'd0,   40,  60, 1'b1, 2, 1'b0};
    plan[3] = '{9'd10,  60,  70, 1'b1, 2, 1'b0};
    plan[4] = '{9'd511, 40,  70, 1'b1, 2, 1'b0};
    plan[5] = '{9'd37,  60,  70, 1'b1, 1, 1'b0};
    plan[6] = '{9'd256, 290, 99, 1'b0, 0, 1'b0};
    plan[7] = '{9'd5,   40,  65, 1'b1, 3, 1'b0};
    plan[8] = '{9'd0,   40,  65, 1'b1, 2, 1'b1};

    repeat (9) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    foreach (script[i]) begin
      if (script[i].is_cfg) set_capacity(script[i].cfg_val);
      else send_op(script[i].item, script[i].typed, script[i].want);
    end

    for (p = 0; p < NUM_PHASES; p++) begin
      send_idle_pct = (p < 3) ? 25 : (p < 6) ? 76 : 0;
      recv_stall_pct = (p < 3) ? 76 : (p < 6) ? 25 : 0;
      cap_val = plan[p].rand_cap ? CW'($urandom_range(2, 255)) : plan[p].cap;
      set_capacity(cap_val);
      run_left = 0;
      bias = plan[p].wr_pct;
      for (n = 0; n < plan[p].n_items; n++) begin
        if (n == plan[p].n_items / 2) drain_results();
        if (run_left == 0) begin
          run_left = $urandom_range(1, 24);
          bias = (plan[p].flip && $urandom_range(1) == 1) ? 100 - plan[p].wr_pct
                                                           : plan[p].wr_pct;
        end
        run_left--;
        send_op(random_op(bias, plan[p].clr_pct, run_left == 0), 1'b0, '0);
      end
    end

    drain_results();
    repeat (10) @(negedge clk);
    if (mismatches == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule
